// ----- rtl/core/three_channel_matrix_multiply_macros.svh -----
// ----------------------------------------------------------------------------
// three_channel_matrix_multiply_macros.svh
// Assertion shorthands for the matrix multiply checker; they expect clk and
// rst_n to be visible where they are used.
// ----------------------------------------------------------------------------
`ifndef THREE_CHANNEL_MATRIX_MULTIPLY_MACROS_SVH
`define THREE_CHANNEL_MATRIX_MULTIPLY_MACROS_SVH

// condition implies the expectation in the next cycle
`define TCMM_ASSERT_NEXT(lbl, cond, expect_expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (expect_expr)) else $error("next-cycle check failed");

// condition implies the expectation in the same cycle
`define TCMM_ASSERT_SAME(lbl, cond, expect_expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> (expect_expr)) else $error("same-cycle check failed");

`endif

// ----- rtl/core/tcmm_pkg.sv -----
// ----------------------------------------------------------------------------
// tcmm_pkg
// Shared types and fixed field widths of the three-channel matrix multiply.
// ----------------------------------------------------------------------------
package tcmm_pkg;

    // fixed field widths of the request and result words
    localparam int POS_BITS  = 6;
    localparam int CHAN_BITS = 8;
    localparam int SUM_BITS  = 22;
    localparam int SIZE_BITS = 7;
    localparam int MODE_BITS = 2;

    // matrix size after reset
    localparam logic [SIZE_BITS-1:0] SIZE_RESET = 7'd64;

    // request opcodes
    typedef enum logic [MODE_BITS-1:0] {
        MODE_IMAGE   = 2'd0,
        MODE_FILTER  = 2'd1,
        MODE_COMPUTE = 2'd2
    } mode_t;

    // sequencer to multiply-accumulate control
    typedef struct packed {
        logic clear;
        logic valid;
        logic last;
    } mac_ctrl_t;

endpackage

// ----- rtl/core/tcmm_ifs.sv -----
// ----------------------------------------------------------------------------
// tcmm_ifs
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface tcmm_req_if;
    logic                               valid;
    logic                               ready;
    logic [tcmm_pkg::MODE_BITS-1:0]     mode;
    logic [tcmm_pkg::POS_BITS-1:0]      row_index;
    logic [tcmm_pkg::POS_BITS-1:0]      col_index;
    logic [tcmm_pkg::CHAN_BITS-1:0]     chan_a_in;
    logic [tcmm_pkg::CHAN_BITS-1:0]     chan_b_in;
    logic [tcmm_pkg::CHAN_BITS-1:0]     chan_c_in;

    modport source (
        output valid, mode, row_index, col_index, chan_a_in, chan_b_in, chan_c_in,
        input  ready
    );
    modport sink (
        input  valid, mode, row_index, col_index, chan_a_in, chan_b_in, chan_c_in,
        output ready
    );
endinterface

interface tcmm_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [tcmm_pkg::POS_BITS-1:0]      row_out;
    logic [tcmm_pkg::POS_BITS-1:0]      col_out;
    logic [tcmm_pkg::SUM_BITS-1:0]      sum_a;
    logic [tcmm_pkg::SUM_BITS-1:0]      sum_b;
    logic [tcmm_pkg::SUM_BITS-1:0]      sum_c;

    modport source (
        output valid, row_out, col_out, sum_a, sum_b, sum_c,
        input  ready
    );
    modport sink (
        input  valid, row_out, col_out, sum_a, sum_b, sum_c,
        output ready
    );
endinterface

// ----- rtl/core/three_channel_matrix_multiply.sv -----
// ----------------------------------------------------------------------------
// three_channel_matrix_multiply
// Per-channel product of an image matrix and a filter matrix held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req carries request words. Mode image or filter writes one entry of the
//   selected matrix at row_index/col_index in the cycle it is accepted; such a
//   word is taken every cycle outside a compute. Mode compute returns one
//   result word on rsp with the three channel sums of image row times filter
//   column. A compute walks the row and column one entry pair per cycle
//   through the read port of each RAM, then through a product stage and an
//   accumulate stage, holding req.ready low until the result is handed on; it
//   skips the walk if min(matrix_size, MAX_SIZE) is 0 or an index >= MAX_SIZE.
//   The result sits in an output register, so loads keep flowing while it
//   waits; a compute that finishes while rsp is stalled holds until rsp frees.
//   cfg_we writes matrix_size; the user must write it only while the block is
//   idle; the block does not enforce it. Reset sets matrix_size to 64 and
//   empties the output register; the RAM contents are undefined until written.
// ----------------------------------------------------------------------------
module three_channel_matrix_multiply #(
    parameter int MAX_SIZE    = 64,
    parameter int SAMPLE_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tcmm_req_if.sink                        req,
    tcmm_rsp_if.source                      rsp,
    input  logic                            cfg_we,
    input  logic [tcmm_pkg::SIZE_BITS-1:0]  cfg_wdata
);

    localparam int SW    = (SAMPLE_BITS < tcmm_pkg::CHAN_BITS) ? SAMPLE_BITS
                                                                : tcmm_pkg::CHAN_BITS;
    localparam int DW    = 3 * SW;
    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = $clog2(DEPTH);

    logic [tcmm_pkg::SIZE_BITS-1:0] size_reg;
    logic                           out_valid_reg;
    logic [tcmm_pkg::POS_BITS-1:0]  row_out_reg;
    logic [tcmm_pkg::POS_BITS-1:0]  col_out_reg;
    logic [tcmm_pkg::SUM_BITS-1:0]  sum_a_reg, sum_b_reg, sum_c_reg;

    logic                           out_free;
    logic                           mac_done;
    logic                           img_we, flt_we, rd_en, res_load;
    logic [AW-1:0]                  waddr, img_raddr, flt_raddr;
    logic [DW-1:0]                  wdata, img_q, flt_q;
    tcmm_pkg::mac_ctrl_t            mac_ctrl;
    logic [tcmm_pkg::POS_BITS-1:0]  seq_row, seq_col;
    logic [tcmm_pkg::SUM_BITS-1:0]  acc_a, acc_b, acc_c;

    // matrix size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= tcmm_pkg::SIZE_RESET;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_wdata;
        end
    end

    // entry packing, low channel first
    assign wdata = {req.chan_c_in[SW-1:0], req.chan_b_in[SW-1:0], req.chan_a_in[SW-1:0]};

    tcmm_seq #(
        .MAX_SIZE (MAX_SIZE)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_mode  (req.mode),
        .req_row   (req.row_index),
        .req_col   (req.col_index),
        .size      (size_reg),
        .out_free  (out_free),
        .mac_done  (mac_done),
        .img_we    (img_we),
        .flt_we    (flt_we),
        .waddr     (waddr),
        .rd_en     (rd_en),
        .img_raddr (img_raddr),
        .flt_raddr (flt_raddr),
        .mac_ctrl  (mac_ctrl),
        .res_load  (res_load),
        .row_out   (seq_row),
        .col_out   (seq_col)
    );

    tcmm_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_img_ram (
        .clk   (clk),
        .we    (img_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (img_raddr),
        .rdata (img_q)
    );

    tcmm_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_flt_ram (
        .clk   (clk),
        .we    (flt_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (flt_raddr),
        .rdata (flt_q)
    );

    tcmm_mac #(
        .SW (SW)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .img_q (img_q),
        .flt_q (flt_q),
        .done  (mac_done),
        .sum_a (acc_a),
        .sum_b (acc_b),
        .sum_c (acc_c)
    );

    // output register valid
    assign out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res_load;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            row_out_reg <= seq_row;
            col_out_reg <= seq_col;
            sum_a_reg   <= acc_a;
            sum_b_reg   <= acc_b;
            sum_c_reg   <= acc_c;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.row_out = row_out_reg;
    assign rsp.col_out = col_out_reg;
    assign rsp.sum_a   = sum_a_reg;
    assign rsp.sum_b   = sum_b_reg;
    assign rsp.sum_c   = sum_c_reg;

endmodule

// ----- rtl/core/tcmm_ram.sv -----
// ----------------------------------------------------------------------------
// tcmm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcmm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/tcmm_mac.sv -----
// ----------------------------------------------------------------------------
// tcmm_mac
// Three-lane multiply-accumulate: registered products, then wrapping sums.
// ----------------------------------------------------------------------------
module tcmm_mac #(
    parameter int SW = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tcmm_pkg::mac_ctrl_t             ctrl,
    input  logic [3*SW-1:0]                 img_q,
    input  logic [3*SW-1:0]                 flt_q,
    output logic                            done,
    output logic [tcmm_pkg::SUM_BITS-1:0]   sum_a,
    output logic [tcmm_pkg::SUM_BITS-1:0]   sum_b,
    output logic [tcmm_pkg::SUM_BITS-1:0]   sum_c
);

    localparam int PW = 2 * SW;

    logic                          pv_reg;
    logic                          plast_reg;
    logic                          done_reg;

    // pipeline valid and end-of-walk flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg    <= 1'b0;
            plast_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            pv_reg    <= ctrl.valid;
            plast_reg <= ctrl.valid & ctrl.last;
            done_reg  <= pv_reg & plast_reg;
        end
    end

    // one lane per channel
    for (genvar lane = 0; lane < 3; lane++)
    begin : g_lane
        logic [PW-1:0]                 prod;
        logic [PW-1:0]                 prod_reg;
        logic [tcmm_pkg::SUM_BITS-1:0] acc_reg;

        assign prod = PW'(img_q[lane*SW +: SW]) * PW'(flt_q[lane*SW +: SW]);

        always_ff @(posedge clk)
        begin
            if (ctrl.valid)
            begin
                prod_reg <= prod;
            end
            if (ctrl.clear)
            begin
                acc_reg <= '0;
            end
            else if (pv_reg)
            begin
                acc_reg <= acc_reg + tcmm_pkg::SUM_BITS'(prod_reg);
            end
        end
    end

    assign done  = done_reg;
    assign sum_a = g_lane[0].acc_reg;
    assign sum_b = g_lane[1].acc_reg;
    assign sum_c = g_lane[2].acc_reg;

endmodule

// ----- rtl/core/tcmm_seq.sv -----
// ----------------------------------------------------------------------------
// tcmm_seq
// Request decoder and walk sequencer: store writes, row/column read addresses
// and hand-off of the finished sums to the output register.
// ----------------------------------------------------------------------------
module tcmm_seq #(
    parameter int MAX_SIZE = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic [tcmm_pkg::MODE_BITS-1:0]      req_mode,
    input  logic [tcmm_pkg::POS_BITS-1:0]       req_row,
    input  logic [tcmm_pkg::POS_BITS-1:0]       req_col,
    input  logic [tcmm_pkg::SIZE_BITS-1:0]      size,
    input  logic                                out_free,
    input  logic                                mac_done,
    output logic                                img_we,
    output logic                                flt_we,
    output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] waddr,
    output logic                                rd_en,
    output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] img_raddr,
    output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] flt_raddr,
    output tcmm_pkg::mac_ctrl_t                 mac_ctrl,
    output logic                                res_load,
    output logic [tcmm_pkg::POS_BITS-1:0]       row_out,
    output logic [tcmm_pkg::POS_BITS-1:0]       col_out
);

    localparam int AW = $clog2(MAX_SIZE * MAX_SIZE);
    localparam int KW = $clog2(MAX_SIZE);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH,
        ST_HOLD
    } state_t;

    state_t                       state_reg, state_next;
    logic [KW-1:0]                k_reg, k_next;
    logic [KW-1:0]                last_k_reg, last_k_next;
    logic [AW-1:0]                img_addr_reg, img_addr_next;
    logic [AW-1:0]                flt_addr_reg, flt_addr_next;
    logic [tcmm_pkg::POS_BITS-1:0] row_reg, row_next;
    logic [tcmm_pkg::POS_BITS-1:0] col_reg, col_next;
    logic                         data_v_reg, data_v_next;
    logic                         data_last_reg, data_last_next;

    logic                         accept;
    logic                         in_range;
    logic [31:0]                  walk_len;
    logic                         is_compute;
    logic                         issue;

    // request decode
    assign accept   = req_valid & req_ready;
    assign in_range = (32'(req_row) < 32'(MAX_SIZE)) && (32'(req_col) < 32'(MAX_SIZE));
    assign walk_len = (32'(size) > 32'(MAX_SIZE)) ? 32'(MAX_SIZE) : 32'(size);
    assign waddr    = AW'(32'(req_row) * 32'(MAX_SIZE) + 32'(req_col));

    always_comb
    begin
        img_we     = 1'b0;
        flt_we     = 1'b0;
        is_compute = 1'b0;
        unique case (tcmm_pkg::mode_t'(req_mode))
            tcmm_pkg::MODE_IMAGE:   img_we     = accept & in_range;
            tcmm_pkg::MODE_FILTER:  flt_we     = accept & in_range;
            tcmm_pkg::MODE_COMPUTE: is_compute = accept;
            default:                is_compute = 1'b0;
        endcase
    end

    // walk issue and next state
    assign issue = (state_reg == ST_WALK);

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        last_k_next    = last_k_reg;
        img_addr_next  = img_addr_reg;
        flt_addr_next  = flt_addr_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        data_v_next    = issue;
        data_last_next = issue && (k_reg == last_k_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_compute)
                begin
                    row_next      = req_row;
                    col_next      = req_col;
                    k_next        = '0;
                    last_k_next   = KW'(walk_len - 32'd1);
                    img_addr_next = AW'(32'(req_row) * 32'(MAX_SIZE));
                    flt_addr_next = AW'(req_col);
                    if (in_range && (walk_len != 32'd0))
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_WALK:
            begin
                k_next        = k_reg + KW'(1);
                img_addr_next = img_addr_reg + AW'(1);
                flt_addr_next = flt_addr_reg + AW'(MAX_SIZE);
                if (k_reg == last_k_reg)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (mac_done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            last_k_reg    <= '0;
            img_addr_reg  <= '0;
            flt_addr_reg  <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            data_v_reg    <= 1'b0;
            data_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            last_k_reg    <= last_k_next;
            img_addr_reg  <= img_addr_next;
            flt_addr_reg  <= flt_addr_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            data_v_reg    <= data_v_next;
            data_last_reg <= data_last_next;
        end
    end

    assign req_ready      = (state_reg == ST_IDLE);
    assign rd_en          = issue;
    assign img_raddr      = img_addr_reg;
    assign flt_raddr      = flt_addr_reg;
    assign mac_ctrl.clear = is_compute;
    assign mac_ctrl.valid = data_v_reg;
    assign mac_ctrl.last  = data_last_reg;
    assign res_load       = (state_reg == ST_HOLD) && out_free;
    assign row_out        = row_reg;
    assign col_out        = col_reg;

endmodule

// ----- rtl/core/tcmm_checker.sv -----
// ----------------------------------------------------------------------------
// tcmm_checker
// Port-level checks of the matrix multiply handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`include "three_channel_matrix_multiply_macros.svh"

module tcmm_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  logic                            req_ready,
    input  logic [tcmm_pkg::MODE_BITS-1:0]  req_mode,
    input  logic                            rsp_valid,
    input  logic                            rsp_ready
);

    logic req_take;

    assign req_take = req_valid && req_ready;

    // a stalled result word stays offered
    `TCMM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

    // a compute occupies the block for at least the next cycle
    `TCMM_ASSERT_NEXT(a_compute_busy, req_take && (req_mode == tcmm_pkg::MODE_COMPUTE),
        !req_ready)

    // loads and unused codes never stall the request channel
    `TCMM_ASSERT_NEXT(a_load_flow, req_take && (req_mode != tcmm_pkg::MODE_COMPUTE),
        req_ready)

    // a result appears only at the end of a compute
    `TCMM_ASSERT_SAME(a_rsp_after_walk, $rose(rsp_valid), !$past(req_ready))

endmodule

bind three_channel_matrix_multiply tcmm_checker u_tcmm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_mode  (req.mode),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready)
);
